>>> design/lsr_pkg.sv
`default_nettype none

package lsr_pkg;

	localparam int COORD_W = 6;

	typedef logic [COORD_W-1:0] coord_t;

	// One walk, ready for the stepping unit: major axis counts up from major0,
	// minor axis moves by slope/len per step toward neg.
	typedef struct packed {
		logic   xmaj;
		logic   neg;
		coord_t major0;
		coord_t minor0;
		coord_t len;
		coord_t slope;
	} job_t;

endpackage

`default_nettype wire

>>> design/lsr_seg_if.sv
`default_nettype none

interface lsr_seg_if import lsr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

`default_nettype wire

>>> design/lsr_pix_if.sv
`default_nettype none

interface lsr_pix_if import lsr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
		output ready);
endinterface

`default_nettype wire

>>> design/lsr_setup.sv
`default_nettype none

module lsr_setup import lsr_pkg::*; #(
	parameter int IMAGE_SIZE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lsr_seg_if.sink    seg,
	output job_t       job,
	output logic       job_valid,
	input  logic       job_ready
);

	localparam coord_t MAX_C = COORD_W'(IMAGE_SIZE - 1);

	logic   v_s1, v_s2;
	coord_t sx_s1, sy_s1, ex_s1, ey_s1;
	job_t   job_s2;
	logic   rdy1, rdy2;

	coord_t adx, ady, ax, ay, bx, by;
	logic   xmaj, swap;
	job_t   job_nx;

	function automatic coord_t clamp(input coord_t c);
		return (c > MAX_C) ? MAX_C : c;
	endfunction

	assign rdy2      = !v_s2 || job_ready;
	assign rdy1      = !v_s1 || rdy2;
	assign seg.ready = rdy1;

	// Order the endpoints along the major axis and derive the walk.
	always_comb begin
		adx  = (ex_s1 > sx_s1) ? ex_s1 - sx_s1 : sx_s1 - ex_s1;
		ady  = (ey_s1 > sy_s1) ? ey_s1 - sy_s1 : sy_s1 - ey_s1;
		xmaj = ady < adx;
		swap = xmaj ? (ex_s1 < sx_s1) : (ey_s1 < sy_s1);
		ax   = swap ? ex_s1 : sx_s1;
		ay   = swap ? ey_s1 : sy_s1;
		bx   = swap ? sx_s1 : ex_s1;
		by   = swap ? sy_s1 : ey_s1;
		job_nx.xmaj   = xmaj;
		job_nx.neg    = xmaj ? (by < ay) : (bx < ax);
		job_nx.major0 = xmaj ? ax : ay;
		job_nx.minor0 = xmaj ? ay : ax;
		job_nx.len    = xmaj ? adx : ady;
		job_nx.slope  = xmaj ? ady : adx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= seg.valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && seg.valid) begin
			sx_s1 <= clamp(seg.start_x);
			sy_s1 <= clamp(seg.start_y);
			ex_s1 <= clamp(seg.end_x);
			ey_s1 <= clamp(seg.end_y);
		end
		if (rdy2 && v_s1) job_s2 <= job_nx;
	end

	assign job       = job_s2;
	assign job_valid = v_s2;

`ifndef SYNTHESIS
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (sx_s1 <= MAX_C && sy_s1 <= MAX_C && ex_s1 <= MAX_C && ey_s1 <= MAX_C))
		else $error("unclamped coordinate in stage 1");
	a_slope_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> job_s2.slope <= job_s2.len)
		else $error("minor delta exceeds major length");
	a_xmaj_strict: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && job_s2.xmaj |-> job_s2.slope < job_s2.len)
		else $error("x-major walk without strictly shorter minor delta");
`endif

endmodule

`default_nettype wire

>>> design/lsr_walk.sv
`default_nettype none

module lsr_walk import lsr_pkg::*; #(
	parameter int IMAGE_SIZE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       job_valid,
	output logic       job_ready,
	lsr_pix_if.source  pix
);

	localparam coord_t MAX_C = COORD_W'(IMAGE_SIZE - 1);

	logic   busy_q, xmaj_q, neg_q;
	coord_t major_q, minor_q, cnt_q, len_q, slope_q, rem_q;

	logic   out_valid_q, last_q;
	coord_t px_q, py_q;

	logic         out_free, emit, at_last, step;
	logic [COORD_W:0] rsum;
	coord_t       rem_nx, minor_nx;

	assign out_free  = !out_valid_q || pix.ready;
	assign emit      = busy_q && out_free;
	assign at_last   = cnt_q == '0;
	assign job_ready = !busy_q || (emit && at_last);

	// Remainder stays below len and slope never exceeds len, so one
	// compare and subtract per step keeps the quotient exact.
	always_comb begin
		rsum     = {1'b0, rem_q} + {1'b0, slope_q};
		step     = rsum >= {1'b0, len_q};
		rem_nx   = step ? COORD_W'(rsum - {1'b0, len_q}) : rsum[COORD_W-1:0];
		minor_nx = !step ? minor_q : (neg_q ? minor_q - 1'b1 : minor_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)  out_valid_q <= busy_q;
			if (job_ready) busy_q      <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= xmaj_q ? major_q : minor_q;
			py_q   <= xmaj_q ? minor_q : major_q;
			last_q <= at_last;
		end
		if (job_ready && job_valid) begin
			xmaj_q  <= job.xmaj;
			neg_q   <= job.neg;
			major_q <= job.major0;
			minor_q <= job.minor0;
			cnt_q   <= job.len;
			len_q   <= job.len;
			slope_q <= job.slope;
			rem_q   <= '0;
		end else if (emit) begin
			major_q <= major_q + 1'b1;
			minor_q <= minor_nx;
			cnt_q   <= cnt_q - 1'b1;
			rem_q   <= rem_nx;
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.pixel_x    = px_q;
	assign pix.pixel_y    = py_q;
	assign pix.last_pixel = last_q;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && len_q != '0 |-> rem_q < len_q)
		else $error("walk remainder out of range");
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (px_q <= MAX_C && py_q <= MAX_C))
		else $error("pixel outside image");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && at_last && !job_valid |=> !busy_q)
		else $error("walker busy after last pixel");
`endif

endmodule

`default_nettype wire

>>> design/line_segment_rasterizer.sv
// Channel  Dir  Beat                                   Role
// seg      in   start_x, start_y, end_x, end_y         one segment to draw
// pix      out  pixel_x, pixel_y, last_pixel           one pixel, last marks end
//
// A segment spends two setup stages (clamp, then order and delta), then the
// stepper emits one pixel beat per cycle while pix is not stalled: major
// length + 1 beats, 1..64 at IMAGE_SIZE 64.
// The stepper is the rate limit; setup stages refill while it walks.
// arst_n clears the valid bits and the stepper's busy flag only.
// A stall on pix holds the output register and the stepper; seg backs up
// through the setup stages without dropping a beat.
`default_nettype none

module line_segment_rasterizer import lsr_pkg::*; #(
	parameter int IMAGE_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lsr_seg_if.sink   seg,
	lsr_pix_if.source pix
);

	// Handoff from the setup stages to the stepper.
	job_t job;
	logic job_valid;
	logic job_ready;

	// Clamp coordinates, pick the major axis and order the endpoints.
	lsr_setup #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	// Step the major axis, advance the minor axis by remainder compare.
	lsr_walk #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.pix       (pix)
	);

endmodule

`default_nettype wire

>>> tb/line_segment_rasterizer_tb.sv
module line_segment_rasterizer_tb;
	import lsr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IMAGE_SIZE   = 64;
	localparam int N_DIRECTED   = 22;
	localparam int N_RANDOM     = 420;
	localparam int LONG_GAP     = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;
	// Worst case: every segment emits 64 pixels and every pixel waits out the
	// longest receiver stall, plus sender gaps and setup stages; take it 3x.
	localparam int CYCLE_LIMIT  = (N_DIRECTED + N_RANDOM) *
		(IMAGE_SIZE * (LONG_GAP + 1) + LONG_GAP + 8) * 3 + HOLD_CYCLES + 1000;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	// One stimulus row. Where typed is set, fx/fy/flast is the single pixel
	// expected back and the predictor is bypassed.
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		logic   typed;
		coord_t fx;
		coord_t fy;
		logic   flast;
	} segment_row_t;

	logic clk;
	logic arst_n;

	lsr_seg_if seg ();
	lsr_pix_if pix ();

	line_segment_rasterizer #(
		.IMAGE_SIZE(IMAGE_SIZE)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.seg   (seg),
		.pix   (pix)
	);

	pixel_t pending_pixels[$];
	int     mismatches;
	int     cycles;
	bit     hold_request;

	// Zero-length segments sit at the four corners and carry their one pixel
	// typed in. The rest cover full-length lines in both walk directions,
	// both slopes on both major axes, the 45 degree tie (walks y-major),
	// segments one step off that tie and shorter segments inside the image.
	segment_row_t directed_rows [N_DIRECTED] = '{
		'{ 0,  0,  0,  0, 1,  0,  0, 1},
		'{63, 63, 63, 63, 1, 63, 63, 1},
		'{ 0, 63,  0, 63, 1,  0, 63, 1},
		'{63,  0, 63,  0, 1, 63,  0, 1},
		'{ 0,  0, 63,  0, 0,  0,  0, 0},
		'{63, 63,  0, 63, 0,  0,  0, 0},
		'{ 0,  0,  0, 63, 0,  0,  0, 0},
		'{63, 63, 63,  0, 0,  0,  0, 0},
		'{ 0,  0, 63, 63, 0,  0,  0, 0},
		'{63,  0,  0, 63, 0,  0,  0, 0},
		'{ 0, 63, 63,  0, 0,  0,  0, 0},
		'{ 0,  0, 63, 62, 0,  0,  0, 0},
		'{63,  0,  0,  1, 0,  0,  0, 0},
		'{ 0,  0, 62, 63, 0,  0,  0, 0},
		'{ 0, 63,  1,  0, 0,  0,  0, 0},
		'{ 5,  5,  6,  5, 0,  0,  0, 0},
		'{ 5,  5,  5,  6, 0,  0,  0, 0},
		'{10, 10, 11, 11, 0,  0,  0, 0},
		'{20, 30, 45, 37, 0,  0,  0, 0},
		'{40, 10,  3, 50, 0,  0,  0, 0},
		'{42, 21, 21, 42, 0,  0,  0, 0},
		'{21, 42, 42, 21, 0,  0,  0, 0}
	};

	// Free-running clock, 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 11) == 0)
			return $urandom_range(12, LONG_GAP);
		return $urandom_range(1, 3);
	endfunction

	function automatic int clip_coord(input int v);
		if (v < 0)
			return 0;
		if (v > IMAGE_SIZE - 1)
			return IMAGE_SIZE - 1;
		return v;
	endfunction

	// num * i / den, rounded toward zero; den is never zero here.
	function automatic int toward_zero(input int num, input int i, input int den);
		int q;
		q = ((num < 0 ? -num : num) * i) / den;
		return num < 0 ? -q : q;
	endfunction

	// Expected pixel walk for one segment, appended to the pending queue.
	function automatic void rasterize_segment(input coord_t ax, input coord_t ay,
		input coord_t bx, input coord_t by);
		int     sx, sy, ex, ey, t, w, h, len;
		bit     xmajor;
		pixel_t p;
		sx = clip_coord(ax);
		sy = clip_coord(ay);
		ex = clip_coord(bx);
		ey = clip_coord(by);
		w = ex - sx;
		h = ey - sy;
		xmajor = (h < 0 ? -h : h) < (w < 0 ? -w : w);
		// walk the major axis upward: swap the endpoints if it runs down
		if ((xmajor && ex < sx) || (!xmajor && ey < sy)) begin
			t = sx; sx = ex; ex = t;
			t = sy; sy = ey; ey = t;
		end
		w = ex - sx;
		h = ey - sy;
		len = xmajor ? w : h;
		// a zero-length segment yields just its start pixel
		if (len == 0) begin
			p.x = coord_t'(sx);
			p.y = coord_t'(sy);
			p.last = 1'b1;
			pending_pixels.push_back(p);
			return;
		end
		for (int i = 0; i <= len; i++) begin
			if (xmajor) begin
				p.x = coord_t'(sx + i);
				p.y = coord_t'(sy + toward_zero(h, i, w));
			end else begin
				p.x = coord_t'(sx + toward_zero(w, i, h));
				p.y = coord_t'(sy + i);
			end
			p.last = (i == len);
			pending_pixels.push_back(p);
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Watchdog: end the run if the pixels never drain.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycles, pending_pixels.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Pixel checker: compare every accepted beat with the oldest expectation.
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pix.valid === 1'b1 && pix.ready === 1'b1) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
					pix.pixel_x, pix.pixel_y, pix.last_pixel));
			end else begin
				want = pending_pixels.pop_front();
				if (pix.pixel_x !== want.x)
					flag_mismatch($sformatf("pixel_x %0d, want %0d (pixel_y want %0d)",
						pix.pixel_x, want.x, want.y));
				if (pix.pixel_y !== want.y)
					flag_mismatch($sformatf("pixel_y %0d, want %0d (pixel_x want %0d)",
						pix.pixel_y, want.y, want.x));
				if (pix.last_pixel !== want.last)
					flag_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
						pix.last_pixel, want.last, want.x, want.y));
			end
		end
	end

	// Pixel receiver. The stall rate drifts between none, light and heavy
	// from one stretch to the next. On request, hold off for a long
	// stretch so the block fills up and backs up onto seg.
	initial begin : pixel_sink
		int stall_pct;
		int phase_left;
		pix.ready <= 1'b0;
		stall_pct = 0;
		phase_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(100, 400);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 50;
				endcase
			end
			phase_left--;
			if (hold_request) begin
				hold_request = 1'b0;
				pix.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pix.ready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				pix.ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
				pix.ready <= 1'b1;
			end else begin
				pix.ready <= 1'b1;
			end
		end
	end

	// Segment sender: directed rows first, then random segments.
	initial begin : segment_source
		segment_row_t row;
		pixel_t       fixed_pixel;
		int           gap_pct;
		int           sgx, sgy, room, d;

		arst_n <= 1'b0;
		seg.valid <= 1'b0;
		seg.start_x <= '0;
		seg.start_y <= '0;
		seg.end_x <= '0;
		seg.end_y <= '0;
		hold_request = 1'b0;
		mismatches = 0;
		cycles = 0;
		gap_pct = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECTED + N_RANDOM; k++) begin
			if (k < N_DIRECTED) begin
				row = directed_rows[k];
			end else begin
				row = '0;
				row.sx = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
				row.sy = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
				case ($urandom_range(0, 19))
					0, 1: begin
						// zero length
						row.ex = row.sx;
						row.ey = row.sy;
					end
					2: begin
						// horizontal
						row.ex = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
						row.ey = row.sy;
					end
					3: begin
						// vertical
						row.ex = row.sx;
						row.ey = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
					end
					4: begin
						// exact diagonal in a random direction
						sgx = $urandom_range(0, 1);
						sgy = $urandom_range(0, 1);
						room = sgx ? IMAGE_SIZE - 1 - row.sx : row.sx;
						d = sgy ? IMAGE_SIZE - 1 - row.sy : row.sy;
						if (d < room)
							room = d;
						d = $urandom_range(0, room);
						row.ex = coord_t'(sgx ? row.sx + d : row.sx - d);
						row.ey = coord_t'(sgy ? row.sy + d : row.sy - d);
					end
					5: begin
						// endpoints on the image corners
						row.sx = coord_t'($urandom_range(0, 1) ? IMAGE_SIZE - 1 : 0);
						row.sy = coord_t'($urandom_range(0, 1) ? IMAGE_SIZE - 1 : 0);
						row.ex = coord_t'($urandom_range(0, 1) ? IMAGE_SIZE - 1 : 0);
						row.ey = coord_t'($urandom_range(0, 1) ? IMAGE_SIZE - 1 : 0);
					end
					6, 7, 8, 9, 10, 11, 12: begin
						// short segment, keeps the run fast
						row.ex = coord_t'(clip_coord(int'(row.sx) + $urandom_range(0, 16) - 8));
						row.ey = coord_t'(clip_coord(int'(row.sy) + $urandom_range(0, 16) - 8));
					end
					default: begin
						row.ex = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
						row.ey = coord_t'($urandom_range(0, IMAGE_SIZE - 1));
					end
				endcase
			end

			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 25;
					default: gap_pct = 70;
				endcase
			end
			// Back-to-back offers while the receiver holds off.
			if (k == N_DIRECTED + 60) begin
				hold_request = 1'b1;
				gap_pct = 0;
			end

			seg.valid <= 1'b1;
			seg.start_x <= row.sx;
			seg.start_y <= row.sy;
			seg.end_x <= row.ex;
			seg.end_y <= row.ey;
			do
				@(posedge clk);
			while (seg.ready !== 1'b1);

			// beat taken at this edge: queue up its pixels
			if (row.typed) begin
				fixed_pixel.x = row.fx;
				fixed_pixel.y = row.fy;
				fixed_pixel.last = row.flast;
				pending_pixels.push_back(fixed_pixel);
			end else begin
				rasterize_segment(row.sx, row.sy, row.ex, row.ey);
			end

			if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
				seg.valid <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
		seg.valid <= 1'b0;

		// Drain, then give stray beats a chance to show up.
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> line_segment_rasterizer.f
design/lsr_pkg.sv
design/lsr_seg_if.sv
design/lsr_pix_if.sv
design/lsr_setup.sv
design/lsr_walk.sv
design/line_segment_rasterizer.sv
tb/line_segment_rasterizer_tb.sv
